FILE: hdl/orf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package orf_pkg;

  localparam int VAL_W   = 44;
  localparam int PLACE_W = 4;
  localparam int POS_W   = 4;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SPEED  = 2'd1;
  localparam logic [1:0] ACT_REPORT = 2'd2;

  localparam logic [7:0] SPEED_RESET = 8'd2;

  // readouts at or above these print as all nines
  localparam logic [63:0] DIST_CAP_MM = 64'd10000000000000;
  localparam logic [63:0] TIME_CAP_MS = 64'd10000000000;

  localparam logic [PLACE_W-1:0] PLACE_SPEED_TOP = 4'd2;
  localparam logic [PLACE_W-1:0] PLACE_DIST_TOP  = 4'd12;
  localparam logic [PLACE_W-1:0] PLACE_TIME_TOP  = 4'd9;
  localparam logic [PLACE_W-1:0] PLACE_UNITS     = 4'd0;
  localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 4'd3;

  typedef enum logic [1:0] {
    NUM_SPEED,
    NUM_DIST,
    NUM_TIME
  } num_sel_e;

  typedef struct packed {
    logic       is_num;
    num_sel_e   sel;
    logic [7:0] ch;
    logic       last;
  } script_t;

  typedef struct packed {
    logic       tick;
    logic       load_speed;
    logic       clear;
    logic       num_load;
    num_sel_e   num_sel;
    logic       num_step;
    logic       num_next;
    logic       out_load;
    logic       out_digit;
    logic [7:0] out_char;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic place_done;
    logic emit_digit;
    logic number_done;
  } status_t;

  function automatic script_t script_item(input logic [POS_W-1:0] pos);
    script_t s;
    s = '{is_num: 1'b0, sel: NUM_SPEED, ch: 8'h20, last: 1'b0};
    case (pos)
      4'd0:  s.ch = 8'h56;
      4'd1:  s.ch = 8'h3D;
      4'd2:  begin
        s.is_num = 1'b1;
        s.sel    = NUM_SPEED;
      end
      4'd3:  s.ch = 8'h20;
      4'd4:  s.ch = 8'h2C;
      4'd5:  s.ch = 8'h44;
      4'd6:  s.ch = 8'h3D;
      4'd7:  begin
        s.is_num = 1'b1;
        s.sel    = NUM_DIST;
      end
      4'd8:  s.ch = 8'h20;
      4'd9:  s.ch = 8'h2C;
      4'd10: s.ch = 8'h54;
      4'd11: s.ch = 8'h3D;
      4'd12: begin
        s.is_num = 1'b1;
        s.sel    = NUM_TIME;
      end
      4'd13: s.ch = 8'h20;
      4'd14: s.ch = 8'h2E;
      4'd15: begin
        s.ch   = 8'h0D;
        s.last = 1'b1;
      end
      default: s.ch = 8'h20;
    endcase
    return s;
  endfunction

  function automatic logic [VAL_W-1:0] pow10(input logic [PLACE_W-1:0] idx);
    logic [VAL_W-1:0] p;
    case (idx)
      4'd0:    p = 44'd1;
      4'd1:    p = 44'd10;
      4'd2:    p = 44'd100;
      4'd3:    p = 44'd1000;
      4'd4:    p = 44'd10000;
      4'd5:    p = 44'd100000;
      4'd6:    p = 44'd1000000;
      4'd7:    p = 44'd10000000;
      4'd8:    p = 44'd100000000;
      4'd9:    p = 44'd1000000000;
      4'd10:   p = 44'd10000000000;
      4'd11:   p = 44'd100000000000;
      4'd12:   p = 44'd1000000000000;
      default: p = 44'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/orf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface orf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] speed_value;

  modport source (output valid, output action, output speed_value, input ready);
  modport sink   (input valid, input action, input speed_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/orf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface orf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/orf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module orf_dpath import orf_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int DIST_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [7:0] speed_value_i,
  output status_t    status_o,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);

  logic [7:0]           speed_q;
  logic [TIME_BITS-1:0] ms_q, ms_d;
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [DIST_BITS:0]   dist_sum;

  logic [VAL_W-1:0]   val_q, val_d;
  logic [VAL_W-1:0]   pow_cur;
  logic [PLACE_W-1:0] place_q, place_d;
  logic [PLACE_W-1:0] last_place_q, last_place_d;
  logic [3:0]         digit_q, digit_d;
  logic               started_q, started_d;
  logic [63:0]        dist_ext, ms_ext;
  logic               dist_big, ms_big;

  logic [7:0] tx_q;
  logic       last_q;

  assign dist_sum = {1'b0, dist_q} + (DIST_BITS+1)'(speed_q);
  assign dist_ext = 64'(dist_q);
  assign ms_ext   = 64'(ms_q);
  assign dist_big = dist_ext >= DIST_CAP_MM;
  assign ms_big   = ms_ext >= TIME_CAP_MS;
  assign pow_cur  = pow10(place_q);

  assign status_o.place_done  = val_q < pow_cur;
  assign status_o.number_done = place_q == last_place_q;
  assign status_o.emit_digit  = (digit_q != 4'd0) || started_q || (place_q == last_place_q);

  // saturating counters
  always_comb begin
    ms_d   = ms_q;
    dist_d = dist_q;
    if (cmd_i.tick) begin
      if (ms_q != '1) begin
        ms_d = ms_q + 1'b1;
      end
      dist_d = dist_sum[DIST_BITS] ? '1 : dist_sum[DIST_BITS-1:0];
    end else if (cmd_i.clear) begin
      ms_d   = '0;
      dist_d = '0;
    end
  end

  // one subtraction of the current power of ten per cycle
  always_comb begin
    val_d        = val_q;
    place_d      = place_q;
    last_place_d = last_place_q;
    digit_d      = digit_q;
    started_d    = started_q;
    if (cmd_i.num_load) begin
      digit_d   = 4'd0;
      started_d = 1'b0;
      case (cmd_i.num_sel)
        NUM_DIST: begin
          val_d        = dist_big ? VAL_W'(DIST_CAP_MM - 64'd1) : dist_ext[VAL_W-1:0];
          place_d      = PLACE_DIST_TOP;
          last_place_d = PLACE_THOUSANDS;
        end
        NUM_TIME: begin
          val_d        = ms_big ? VAL_W'(TIME_CAP_MS - 64'd1) : ms_ext[VAL_W-1:0];
          place_d      = PLACE_TIME_TOP;
          last_place_d = PLACE_THOUSANDS;
        end
        default: begin
          val_d        = VAL_W'(speed_q);
          place_d      = PLACE_SPEED_TOP;
          last_place_d = PLACE_UNITS;
        end
      endcase
    end else if (cmd_i.num_step) begin
      val_d   = val_q - pow_cur;
      digit_d = digit_q + 4'd1;
    end else if (cmd_i.num_next) begin
      place_d   = place_q - 1'b1;
      digit_d   = 4'd0;
      started_d = started_q | status_o.emit_digit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
      ms_q    <= '0;
      dist_q  <= '0;
    end else begin
      if (cmd_i.load_speed) begin
        speed_q <= speed_value_i;
      end
      ms_q   <= ms_d;
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    place_q      <= place_d;
    last_place_q <= last_place_d;
    digit_q      <= digit_d;
    started_q    <= started_d;
    if (cmd_i.out_load) begin
      tx_q   <= cmd_i.out_digit ? (8'h30 | {4'd0, digit_q}) : cmd_i.out_char;
      last_q <= cmd_i.out_last;
    end
  end

  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

endmodule

`default_nettype wire

FILE: hdl/orf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module orf_ctrl import orf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUT,
    S_CONV
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  script_t          item;

  assign slot_free = !out_valid_q || out_ready_i;
  assign item      = script_item(pos_q);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_TICK:   cmd_o.tick = 1'b1;
            ACT_SPEED:  cmd_o.load_speed = 1'b1;
            ACT_REPORT: begin
              state_d = S_PUT;
              pos_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_PUT: begin
        if (item.is_num) begin
          cmd_o.num_load = 1'b1;
          cmd_o.num_sel  = item.sel;
          state_d        = S_CONV;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_char = item.ch;
          cmd_o.out_last = item.last;
          out_valid_d    = 1'b1;
          if (item.last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      S_CONV: begin
        if (!status_i.place_done) begin
          cmd_o.num_step = 1'b1;
        end else if (!status_i.emit_digit) begin
          // leading zero
          cmd_o.num_next = 1'b1;
        end else if (slot_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_digit = 1'b1;
          out_valid_d     = 1'b1;
          if (status_i.number_done) begin
            pos_d   = pos_q + 1'b1;
            state_d = S_PUT;
          end else begin
            cmd_o.num_next = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten while stalled");

  a_report_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ACT_REPORT) |=> (state_q == S_PUT && pos_q == '0))
    else $error("report did not start at first character");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> (state_q == S_IDLE && out_valid_q))
    else $error("last word did not end the report");

  a_step_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.num_step |-> (state_q == S_CONV && !status_i.place_done))
    else $error("subtraction past the current place");

endmodule

`default_nettype wire

FILE: hdl/odometer_report_formatter.sv
// tick and speed words are acted on when accepted; a new word is accepted on the next cycle
// a report sends each literal character and loads each number; per decimal place
// it subtracts the power of ten once per unit of the digit, then sends the digit,
// which is skipped if it is a leading zero
// async active-low reset: speed 2, millisecond and distance counters zero, idle
`timescale 1ns / 1ps
`default_nettype none

module odometer_report_formatter import orf_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int DIST_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  orf_in_if.sink     in_i,
  orf_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;

  orf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .action_i    (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  orf_dpath #(
    .TIME_BITS (TIME_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .speed_value_i (in_i.speed_value),
    .status_o      (status),
    .tx_byte_o     (out_o.tx_byte),
    .last_byte_o   (out_o.last_byte)
  );

endmodule

`default_nettype wire
